>>> rtl/core/isle_pkg.sv
`default_nettype none
package isle_pkg;

   localparam int CAPACITY = 32;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic signed [31:0] data_type;

   typedef enum logic [3:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_APPEND     = 4'd1,
      CMD_INSERT_AT  = 4'd2,
      CMD_POP_FRONT  = 4'd3,
      CMD_POP_BACK   = 4'd4,
      CMD_DELETE_AT  = 4'd5,
      CMD_GET_AT     = 4'd6,
      CMD_CONTAINS   = 4'd7,
      CMD_INDEX_OF   = 4'd8,
      CMD_REVERSE    = 4'd9,
      CMD_CLEAR      = 4'd10
   } command_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BOUNDS    = 3'd1,
      ST_FULL      = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE,
      OP_GET,
      OP_CONTAINS,
      OP_INDEX_OF
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LINK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic     en;
      slot_type addr;
   } store_rd_type;

   typedef struct packed {
      logic     val_we;
      slot_type val_addr;
      data_type val_data;
      logic     nxt_we;
      slot_type nxt_addr;
      slot_type nxt_data;
      logic     prv_we;
      slot_type prv_addr;
      slot_type prv_data;
   } store_wr_type;

   typedef struct packed {
      data_type value;
      slot_type nxt;
      slot_type prv;
   } store_q_type;

endpackage
`default_nettype wire

>>> rtl/core/isle_req_if.sv
`default_nettype none
interface isle_req_if;
   logic             valid;
   logic             ready;
   logic [3:0]       command;
   logic [5:0]       element_index;
   isle_pkg::data_type data_value;

   modport source (output valid, command, element_index, data_value, input ready);
   modport sink   (input valid, command, element_index, data_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/isle_rsp_if.sv
`default_nettype none
interface isle_rsp_if;
   logic             valid;
   logic             ready;
   logic [2:0]       status;
   isle_pkg::data_type read_value;
   logic [4:0]       match_index;
   logic             found;
   logic [5:0]       element_count;
   logic             last;

   modport source (output valid, status, read_value, match_index, found, element_count,
                   last, input ready);
   modport sink   (input valid, status, read_value, match_index, found, element_count,
                   last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/isle_store.sv
`default_nettype none
module isle_store (
   input  wire logic                   clock,
   input  wire isle_pkg::store_rd_type rd,
   input  wire isle_pkg::store_wr_type wr,
   output isle_pkg::store_q_type       q
);
   import isle_pkg::*;

   data_type value_mem [CAPACITY];
   slot_type next_mem  [CAPACITY];
   slot_type prev_mem  [CAPACITY];

   data_type value_ff;
   slot_type next_ff;
   slot_type prev_ff;

   always_ff @(posedge clock) begin
      if (wr.val_we) begin
         value_mem[wr.val_addr] <= wr.val_data;
      end
      if (rd.en) begin
         value_ff <= value_mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.nxt_we) begin
         next_mem[wr.nxt_addr] <= wr.nxt_data;
      end
      if (rd.en) begin
         next_ff <= next_mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.prv_we) begin
         prev_mem[wr.prv_addr] <= wr.prv_data;
      end
      if (rd.en) begin
         prev_ff <= prev_mem[rd.addr];
      end
   end

   assign q.value = value_ff;
   assign q.nxt   = next_ff;
   assign q.prv   = prev_ff;

endmodule
`default_nettype wire

>>> rtl/core/isle_ctrl.sv
`default_nettype none
module isle_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   isle_req_if.sink                   req,
   isle_rsp_if.source                 rsp,
   output isle_pkg::store_rd_type     rd,
   output isle_pkg::store_wr_type     wr,
   input  wire isle_pkg::store_q_type q
);
   import isle_pkg::*;

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   count_type  tgt_ff, tgt_in;
   data_type   val_ff, val_in;
   slot_type   cur_ff, cur_in;
   slot_type   idx_ff, idx_in;
   slot_type   new_ff, new_in;
   slot_type   succ_ff, succ_in;
   slot_type   head_ff, head_in;
   slot_type   tail_ff, tail_in;
   count_type  count_ff, count_in;
   logic       rev_ff, rev_in;
   count_type  top_ff, top_in;
   slot_type   free_ff [CAPACITY];
   slot_type   free_in [CAPACITY];
   status_type st_ff, st_in;
   data_type   rv_ff, rv_in;
   logic       fd_ff, fd_in;
   logic       pend_ff, pend_in;
   slot_type   pidx_ff, pidx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type out_st_ff, out_st_in;
   data_type   out_rv_ff, out_rv_in;
   slot_type   out_mi_ff, out_mi_in;
   logic       out_fd_ff, out_fd_in;
   count_type  out_cnt_ff, out_cnt_in;
   logic       out_last_ff, out_last_in;

   slot_type   front, back, fwd_q, bwd_q, free_slot;
   count_type  last_pos;
   logic       out_free, at_tgt, at_end, match;

   assign front     = rev_ff ? tail_ff : head_ff;
   assign back      = rev_ff ? head_ff : tail_ff;
   assign fwd_q     = rev_ff ? q.prv : q.nxt;
   assign bwd_q     = rev_ff ? q.nxt : q.prv;
   assign free_slot = free_ff[SLOT_W'(top_ff - 1'b1)];
   assign last_pos  = count_ff - 1'b1;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign at_tgt    = CNT_W'(idx_ff) == tgt_ff;
   assign at_end    = CNT_W'(idx_ff) == last_pos;
   assign match     = q.value == val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_NONE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         top_ff       <= CNT_W'(CAPACITY);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            free_ff[i] <= SLOT_W'(i);
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         top_ff       <= top_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      val_ff      <= val_in;
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      new_ff      <= new_in;
      succ_ff     <= succ_in;
      st_ff       <= st_in;
      rv_ff       <= rv_in;
      fd_ff       <= fd_in;
      pidx_ff     <= pidx_in;
      out_st_ff   <= out_st_in;
      out_rv_ff   <= out_rv_in;
      out_mi_ff   <= out_mi_in;
      out_fd_ff   <= out_fd_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      count_type  ipos;
      count_type  dpos;
      logic       do_ins;
      logic       do_del;
      logic       fw_we;
      slot_type   fw_addr;
      slot_type   fw_data;
      logic       bw_we;
      slot_type   bw_addr;
      slot_type   bw_data;
      logic       emit;
      status_type e_st;
      slot_type   e_mi;
      logic       e_fd;
      logic       e_last;
      data_type   e_rv;

      state_in = state_ff;
      op_in    = op_ff;
      tgt_in   = tgt_ff;
      val_in   = val_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      new_in   = new_ff;
      succ_in  = succ_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      top_in   = top_ff;
      free_in  = free_ff;
      st_in    = st_ff;
      rv_in    = rv_ff;
      fd_in    = fd_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;

      ipos    = '0;
      dpos    = '0;
      do_ins  = 1'b0;
      do_del  = 1'b0;
      fw_we   = 1'b0;
      fw_addr = '0;
      fw_data = '0;
      bw_we   = 1'b0;
      bw_addr = '0;
      bw_data = '0;
      emit    = 1'b0;
      e_st    = ST_OK;
      e_rv    = '0;
      e_mi    = '0;
      e_fd    = 1'b0;
      e_last  = 1'b0;
      rd      = '0;
      wr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               st_in    = ST_OK;
               rv_in    = '0;
               fd_in    = 1'b0;
               pend_in  = 1'b0;
               op_in    = OP_NONE;
               val_in   = req.data_value;
               tgt_in   = req.element_index;
               state_in = S_RESP;
               unique case (req.command)
                  CMD_PUSH_FRONT: begin
                     do_ins = 1'b1;
                     ipos   = '0;
                  end
                  CMD_APPEND: begin
                     do_ins = 1'b1;
                     ipos   = count_ff;
                  end
                  CMD_INSERT_AT: begin
                     do_ins = 1'b1;
                     ipos   = req.element_index;
                  end
                  CMD_POP_FRONT: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;
                     end else begin
                        do_del = 1'b1;
                        dpos   = '0;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;
                     end else begin
                        do_del = 1'b1;
                        dpos   = last_pos;
                     end
                  end
                  CMD_DELETE_AT: begin
                     do_del = 1'b1;
                     dpos   = req.element_index;
                  end
                  CMD_GET_AT: begin
                     if (req.element_index >= count_ff) begin
                        st_in = ST_BOUNDS;
                     end else begin
                        op_in    = OP_GET;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_CONTAINS: begin
                     if (count_ff == '0) begin
                        st_in = ST_NOT_FOUND;
                     end else begin
                        op_in    = OP_CONTAINS;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_INDEX_OF: begin
                     if (count_ff == '0) begin
                        st_in = ST_NOT_FOUND;
                     end else begin
                        op_in    = OP_INDEX_OF;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_REVERSE: begin
                     rev_in = !rev_ff;
                  end
                  CMD_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                     rev_in   = 1'b0;
                     top_in   = CNT_W'(CAPACITY);
                     for (int i = 0; i < CAPACITY; i++) begin
                        free_in[i] = SLOT_W'(i);
                     end
                  end
                  default: begin
                  end
               endcase

               if (do_ins) begin
                  if (ipos > count_ff) begin
                     st_in = ST_BOUNDS;
                  end else if (count_ff == CNT_W'(CAPACITY)) begin
                     st_in = ST_FULL;
                  end else begin
                     top_in      = top_ff - 1'b1;
                     new_in      = free_slot;
                     count_in    = count_ff + 1'b1;
                     wr.val_we   = 1'b1;
                     wr.val_addr = free_slot;
                     wr.val_data = req.data_value;
                     if (count_ff == '0) begin
                        head_in = free_slot;
                        tail_in = free_slot;
                     end else if (ipos == '0) begin
                        fw_we   = 1'b1;
                        fw_addr = free_slot;
                        fw_data = front;
                        bw_we   = 1'b1;
                        bw_addr = front;
                        bw_data = free_slot;
                        if (rev_ff) begin
                           tail_in = free_slot;
                        end else begin
                           head_in = free_slot;
                        end
                     end else if (ipos == count_ff) begin
                        bw_we   = 1'b1;
                        bw_addr = free_slot;
                        bw_data = back;
                        fw_we   = 1'b1;
                        fw_addr = back;
                        fw_data = free_slot;
                        if (rev_ff) begin
                           head_in = free_slot;
                        end else begin
                           tail_in = free_slot;
                        end
                     end else begin
                        op_in    = OP_INSERT;
                        tgt_in   = ipos - 1'b1;
                        state_in = S_SCAN;
                     end
                  end
               end

               if (do_del) begin
                  if (dpos >= count_ff) begin
                     st_in = ST_BOUNDS;
                  end else begin
                     op_in    = OP_DELETE;
                     tgt_in   = dpos;
                     state_in = S_SCAN;
                  end
               end

               if (state_in == S_SCAN) begin
                  rd.en   = 1'b1;
                  rd.addr = front;
                  cur_in  = front;
                  idx_in  = '0;
               end
            end
         end

         S_SCAN: begin
            unique case (op_ff)
               OP_INSERT: begin
                  if (at_tgt) begin
                     fw_we    = 1'b1;
                     fw_addr  = new_ff;
                     fw_data  = fwd_q;
                     bw_we    = 1'b1;
                     bw_addr  = new_ff;
                     bw_data  = cur_ff;
                     succ_in  = fwd_q;
                     state_in = S_LINK;
                  end else begin
                     rd.en   = 1'b1;
                     rd.addr = fwd_q;
                     cur_in  = fwd_q;
                     idx_in  = idx_ff + 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (at_tgt) begin
                     if (count_ff == CNT_W'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else if (tgt_ff == '0) begin
                        if (rev_ff) begin
                           tail_in = fwd_q;
                        end else begin
                           head_in = fwd_q;
                        end
                     end else if (tgt_ff == last_pos) begin
                        if (rev_ff) begin
                           head_in = bwd_q;
                        end else begin
                           tail_in = bwd_q;
                        end
                     end else begin
                        fw_we   = 1'b1;
                        fw_addr = bwd_q;
                        fw_data = fwd_q;
                        bw_we   = 1'b1;
                        bw_addr = fwd_q;
                        bw_data = bwd_q;
                     end
                     if (top_ff < CNT_W'(CAPACITY)) begin
                        free_in[top_ff[SLOT_W-1:0]] = cur_ff;
                        top_in = top_ff + 1'b1;
                     end
                     count_in = count_ff - 1'b1;
                     state_in = S_RESP;
                  end else begin
                     rd.en   = 1'b1;
                     rd.addr = fwd_q;
                     cur_in  = fwd_q;
                     idx_in  = idx_ff + 1'b1;
                  end
               end
               OP_GET: begin
                  if (at_tgt) begin
                     rv_in    = q.value;
                     state_in = S_RESP;
                  end else begin
                     rd.en   = 1'b1;
                     rd.addr = fwd_q;
                     cur_in  = fwd_q;
                     idx_in  = idx_ff + 1'b1;
                  end
               end
               OP_CONTAINS: begin
                  if (match) begin
                     fd_in    = 1'b1;
                     state_in = S_RESP;
                  end else if (at_end) begin
                     st_in    = ST_NOT_FOUND;
                     state_in = S_RESP;
                  end else begin
                     rd.en   = 1'b1;
                     rd.addr = fwd_q;
                     cur_in  = fwd_q;
                     idx_in  = idx_ff + 1'b1;
                  end
               end
               OP_INDEX_OF: begin
                  if (!(match && pend_ff && !out_free)) begin
                     if (match) begin
                        if (pend_ff) begin
                           emit = 1'b1;
                           e_st = ST_OK;
                           e_mi = pidx_ff;
                           e_fd = 1'b1;
                        end
                        pend_in = 1'b1;
                        pidx_in = idx_ff;
                     end
                     if (at_end) begin
                        state_in = S_RESP;
                     end else begin
                        rd.en   = 1'b1;
                        rd.addr = fwd_q;
                        cur_in  = fwd_q;
                        idx_in  = idx_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_LINK: begin
            fw_we    = 1'b1;
            fw_addr  = cur_ff;
            fw_data  = new_ff;
            bw_we    = 1'b1;
            bw_addr  = succ_ff;
            bw_data  = new_ff;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               emit   = 1'b1;
               e_last = 1'b1;
               if (op_ff == OP_INDEX_OF) begin
                  e_st = pend_ff ? ST_OK : ST_NOT_FOUND;
                  e_mi = pend_ff ? pidx_ff : '0;
                  e_fd = pend_ff;
               end else begin
                  e_st = st_ff;
                  e_rv = rv_ff;
                  e_fd = fd_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // fwd and bwd links swap roles while the list is reversed
      if (rev_ff) begin
         wr.prv_we   = fw_we;
         wr.prv_addr = fw_addr;
         wr.prv_data = fw_data;
         wr.nxt_we   = bw_we;
         wr.nxt_addr = bw_addr;
         wr.nxt_data = bw_data;
      end else begin
         wr.nxt_we   = fw_we;
         wr.nxt_addr = fw_addr;
         wr.nxt_data = fw_data;
         wr.prv_we   = bw_we;
         wr.prv_addr = bw_addr;
         wr.prv_data = bw_data;
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_st_in    = out_st_ff;
      out_rv_in    = out_rv_ff;
      out_mi_in    = out_mi_ff;
      out_fd_in    = out_fd_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         out_st_in    = e_st;
         out_rv_in    = e_rv;
         out_mi_in    = e_mi;
         out_fd_in    = e_fd;
         out_cnt_in   = count_in;
         out_last_in  = e_last;
      end
   end

   assign req.ready         = state_ff == S_IDLE;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = out_st_ff;
   assign rsp.read_value    = out_rv_ff;
   assign rsp.match_index   = out_mi_ff;
   assign rsp.found         = out_fd_ff;
   assign rsp.element_count = out_cnt_ff;
   assign rsp.last          = out_last_ff;

endmodule
`default_nettype wire

>>> rtl/core/indexed_sequence_list_engine.sv
// no-walk commands go from S_IDLE straight to S_RESP; indexed commands and searches walk
// the list in S_SCAN over the single read port of the entry memories
// one word at a time; the next word is taken once the final result sits in the output
// register; walks read one link per cycle unless output stalls
// reset: list empty, all slots free, direction forward; entry memories are not cleared
`default_nettype none
module indexed_sequence_list_engine (
   input  wire logic  clock,
   input  wire logic  reset,
   isle_req_if.sink   req_if,
   isle_rsp_if.source rsp_if
);
   import isle_pkg::*;

   store_rd_type rd;
   store_wr_type wr;
   store_q_type  q;

   isle_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .rd    (rd),
      .wr    (wr),
      .q     (q)
   );

   isle_store u_store (
      .clock (clock),
      .rd    (rd),
      .wr    (wr),
      .q     (q)
   );

endmodule
`default_nettype wire
